// ===== src/aor_pkg.sv =====
// Shared constants, types and arithmetic helpers of the alpha over-opacity repair block.
`timescale 1ns / 1ps

package aor_pkg;

  // Number of weight lanes carried by one texel, and the largest layer count honored.
  localparam int NLANES      = 4;
  localparam int MAX_LAYERS  = 4;

  localparam int WEIGHT_W    = 8;
  localparam int SUM_W       = 10;
  localparam int NUM_W       = 16;
  localparam logic [SUM_W-1:0] OPAQUE = 10'd255;

  // Pipelined restoring divider: quotient bits per lane and bits resolved per stage.
  localparam int QBITS          = 8;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = QBITS / BITS_PER_STAGE;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_LAYERS        = 2'd0;
  localparam logic [1:0] REG_SCALE_MODE    = 2'd1;
  localparam logic [1:0] REG_REPAIR_ENABLE = 2'd2;

  // Per-texel control that travels beside the lane data.
  typedef struct packed {
    logic             repaired;
    logic             prop;
    logic             clip;
    logic [SUM_W-1:0] excess;
  } aor_ctrl_t;

  // One restoring division step: returns {quotient bit, new partial remainder}.
  function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] rem,
                                               input logic [SUM_W-1:0] dv,
                                               input logic [2:0] sh);
    logic [NUM_W+1:0] d;
    logic [NUM_W+1:0] r;
    d = (NUM_W+2)'(dv) << sh;
    r = (NUM_W+2)'(rem);
    if (r >= d) begin
      div_step = {1'b1, NUM_W'(r - d)};
    end else begin
      div_step = {1'b0, rem};
    end
  endfunction

endpackage

// ===== src/aor_lane.sv =====
// One weight lane: clip cut plus a pipelined restoring divider for the proportional quotient.
`timescale 1ns / 1ps

module aor_lane import aor_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] adv,
  input  logic [WEIGHT_W-1:0]   weight,
  input  logic [SUM_W-1:0]      prefix,
  input  logic [SUM_W-1:0]      total,
  input  logic                  clip,
  output logic [WEIGHT_W-1:0]   quo,
  output logic [SUM_W-1:0]      rem,
  output logic [WEIGHT_W-1:0]   base
);

  logic [NUM_W-1:0]    rem_q  [DIV_STAGES];
  logic [QBITS-1:0]    quo_q  [DIV_STAGES];
  logic [SUM_W-1:0]    div_q  [DIV_STAGES];
  logic [WEIGHT_W-1:0] base_q [DIV_STAGES];

  logic [NUM_W-1:0]    rem_in  [DIV_STAGES];
  logic [QBITS-1:0]    quo_in  [DIV_STAGES];
  logic [SUM_W-1:0]    div_in  [DIV_STAGES];
  logic [WEIGHT_W-1:0] base_in [DIV_STAGES];

  logic [WEIGHT_W-1:0] keep;
  logic [SUM_W-1:0]    room;

  // Clip mode: a layer keeps what is left of the opaque budget after the layers below it.
  always_comb begin
    room = OPAQUE - prefix;
    if (prefix >= OPAQUE) begin
      keep = '0;
    end else if (SUM_W'(weight) < room) begin
      keep = weight;
    end else begin
      keep = room[WEIGHT_W-1:0];
    end
  end

  always_comb begin
    rem_in[0]  = {weight, 8'd0} - NUM_W'(weight);
    quo_in[0]  = '0;
    div_in[0]  = total;
    base_in[0] = clip ? keep : weight;
    for (int j = 1; j < DIV_STAGES; j++) begin
      rem_in[j]  = rem_q[j-1];
      quo_in[j]  = quo_q[j-1];
      div_in[j]  = div_q[j-1];
      base_in[j] = base_q[j-1];
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [NUM_W-1:0] r;
    logic [QBITS-1:0] q;

    always_comb begin
      logic [NUM_W:0] st;
      r = rem_in[j];
      q = quo_in[j];
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        st = div_step(r, div_in[j], 3'(QBITS - 1 - (BITS_PER_STAGE * j + b)));
        r  = st[NUM_W-1:0];
        q  = {q[QBITS-2:0], st[NUM_W]};
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        rem_q[j]  <= r;
        quo_q[j]  <= q;
        div_q[j]  <= div_in[j];
        base_q[j] <= base_in[j];
      end
    end
  end

  assign quo  = quo_q[DIV_STAGES-1];
  assign rem  = rem_q[DIV_STAGES-1][SUM_W-1:0];
  assign base = base_q[DIV_STAGES-1];

endmodule

// ===== src/aor_merge.sv =====
// Merging stage: hands leftover units to the largest remainders and selects each lane's result.
`timescale 1ns / 1ps

module aor_merge import aor_pkg::*; (
  input  logic [WEIGHT_W-1:0] quo   [NLANES],
  input  logic [SUM_W-1:0]    rem   [NLANES],
  input  logic [WEIGHT_W-1:0] base  [NLANES],
  input  aor_ctrl_t           ctrl,
  output logic [WEIGHT_W-1:0] fixed [NLANES]
);

  always_comb begin
    logic [SUM_W-1:0]    given;
    logic [SUM_W-1:0]    left;
    logic [2:0]          rank;
    logic                bonus;
    logic [WEIGHT_W:0]   inc;
    given = '0;
    for (int k = 0; k < NLANES; k++) begin
      given = given + SUM_W'(quo[k]);
    end
    left = (given < OPAQUE) ? OPAQUE - given : '0;
    for (int k = 0; k < NLANES; k++) begin
      // Rank among all lanes: larger remainder first, lower index first on a tie.
      rank = '0;
      for (int j = 0; j < NLANES; j++) begin
        if (j != k && (rem[j] > rem[k] || (rem[j] == rem[k] && j < k))) begin
          rank = rank + 3'd1;
        end
      end
      bonus = (rem[k] != '0) && (SUM_W'(rank) < left);
      inc   = (WEIGHT_W+1)'(quo[k]) + (WEIGHT_W+1)'(bonus);
      if (ctrl.prop) begin
        fixed[k] = inc[WEIGHT_W] ? '1 : inc[WEIGHT_W-1:0];
      end else begin
        fixed[k] = base[k];
      end
    end
  end

endmodule

// ===== src/alpha_over_opacity_repair.sv =====
// Top level of the alpha over-opacity repair block: config registers, lane pipeline, output.
`timescale 1ns / 1ps

// Repairs one texel's four 8-bit alpha layer weights per request. Layers at or above the
// layer count read as zero; when the active sum exceeds 255 and repair is on, the weights are
// clipped from the top layer down or rescaled by largest remainder. One texel is taken every
// clock cycle while the output is not stalled, and passes through one input stage, four divider
// stages that resolve two quotient bits each in every lane, and the output register where the
// lanes' results are merged. Each stage moves on whenever the stage after it is free, so bubbles
// close up behind a stalled output. The user must write the configuration registers through the
// APB port only while no texel is in flight; the block itself does not enforce this.
module alpha_over_opacity_repair import aor_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // weight_0 [7:0], weight_1 [15:8], weight_2 [23:16], weight_3 [31:24]
  input  logic [31:0]       s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // fixed_0 [7:0], fixed_1 [15:8], fixed_2 [23:16], fixed_3 [31:24],
  // excess_amount [41:32], zero fill [47:42]
  output logic [47:0]       m_axis_tdata,
  // was_repaired [0]
  output logic              m_axis_tuser
);

  localparam int NSTG = DIV_STAGES + 2;

  logic [2:0] num_layers;
  logic       scale_mode;
  logic       repair_enable;

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] rdy;

  logic [WEIGHT_W-1:0] w_in   [NLANES];
  logic [SUM_W-1:0]    pre_in [NLANES];
  logic [SUM_W-1:0]    sum_in;
  aor_ctrl_t           ctrl_in;

  logic [WEIGHT_W-1:0] w_s1   [NLANES];
  logic [SUM_W-1:0]    pre_s1 [NLANES];
  logic [SUM_W-1:0]    sum_s1;
  aor_ctrl_t           ctrl_q [DIV_STAGES+1];

  logic [WEIGHT_W-1:0] quo_l  [NLANES];
  logic [SUM_W-1:0]    rem_l  [NLANES];
  logic [WEIGHT_W-1:0] base_l [NLANES];
  logic [WEIGHT_W-1:0] merged [NLANES];

  logic [WEIGHT_W-1:0] out_fixed [NLANES];
  aor_ctrl_t           out_ctrl;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_layers    <= 3'd4;
      scale_mode    <= 1'b0;
      repair_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_LAYERS:        num_layers    <= pwdata[2:0];
        REG_SCALE_MODE:    scale_mode    <= pwdata[0];
        REG_REPAIR_ENABLE: repair_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LAYERS:        prdata = DATA_W'(num_layers);
      REG_SCALE_MODE:    prdata = DATA_W'(scale_mode);
      REG_REPAIR_ENABLE: prdata = DATA_W'(repair_enable);
      default:           prdata = '0;
    endcase
  end

  // Stage handshake: a stage loads when it is empty or its contents move on.
  always_comb begin
    rdy[NSTG-1] = !v[NSTG-1] || m_axis_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Masking of inactive layers, prefix sums and the texel's control word.
  always_comb begin
    logic [2:0] eff;
    eff = (num_layers > 3'(MAX_LAYERS)) ? 3'(MAX_LAYERS) : num_layers;
    sum_in = '0;
    for (int k = 0; k < NLANES; k++) begin
      w_in[k]   = (3'(k) < eff) ? s_axis_tdata[k*WEIGHT_W +: WEIGHT_W] : '0;
      pre_in[k] = sum_in;
      sum_in    = sum_in + SUM_W'(w_in[k]);
    end
    ctrl_in.excess   = (sum_in > OPAQUE) ? sum_in - OPAQUE : '0;
    ctrl_in.repaired = (sum_in > OPAQUE) && repair_enable;
    ctrl_in.prop     = ctrl_in.repaired && scale_mode;
    ctrl_in.clip     = ctrl_in.repaired && !scale_mode;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      w_s1      <= w_in;
      pre_s1    <= pre_in;
      sum_s1    <= sum_in;
      ctrl_q[0] <= ctrl_in;
    end
    for (int i = 1; i <= DIV_STAGES; i++) begin
      if (rdy[i]) begin
        ctrl_q[i] <= ctrl_q[i-1];
      end
    end
  end

  for (genvar k = 0; k < NLANES; k++) begin : g_lane
    aor_lane u_lane (
      .clk    (clk),
      .adv    (rdy[DIV_STAGES:1]),
      .weight (w_s1[k]),
      .prefix (pre_s1[k]),
      .total  (sum_s1),
      .clip   (ctrl_q[0].clip),
      .quo    (quo_l[k]),
      .rem    (rem_l[k]),
      .base   (base_l[k])
    );
  end

  aor_merge u_merge (
    .quo   (quo_l),
    .rem   (rem_l),
    .base  (base_l),
    .ctrl  (ctrl_q[DIV_STAGES]),
    .fixed (merged)
  );

  always_ff @(posedge clk) begin
    if (rdy[NSTG-1]) begin
      out_fixed <= merged;
      out_ctrl  <= ctrl_q[DIV_STAGES];
    end
  end

  assign m_axis_tdata = {6'd0, out_ctrl.excess,
                         out_fixed[3], out_fixed[2], out_fixed[1], out_fixed[0]};
  assign m_axis_tuser = out_ctrl.repaired;

`ifndef SYNTHESIS
  // A repaired texel always comes out exactly opaque.
  a_repaired_opaque: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      (10'(m_axis_tdata[7:0]) + 10'(m_axis_tdata[15:8]) + 10'(m_axis_tdata[23:16])
       + 10'(m_axis_tdata[31:24])) == OPAQUE)
    else $error("repaired texel does not sum to opaque");

  // Repair only happens where there was an excess.
  a_repair_needs_excess: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[41:32] != 10'd0)
    else $error("repaired flag without excess");

  // Input back-pressure only comes from a full pipeline behind a waiting result.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && (&v))
    else $error("input stalled while a stage is free");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the alpha over-opacity repair block.
`timescale 1ns / 1ps

module testbench;
  import aor_pkg::*;

  localparam int PIPE_DEPTH    = 6;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 153;
  localparam int LONG_HOLD_AT  = 200;
  localparam int LONG_HOLD_LEN = 80;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [3:0][7:0]  fixed;
    logic [SUM_W-1:0] excess;
    logic             repaired;
  } texel_fix_t;

  typedef struct packed {
    logic [2:0]  layers;
    logic        scale;
    logic        repair;
    logic [31:0] texel;
    logic        known;
    texel_fix_t  want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [47:0]       m_axis_tdata;
  logic              m_axis_tuser;

  // Local copy of the configuration registers.
  logic [2:0] cfg_layers = 3'd4;
  logic       cfg_scale  = 1'b0;
  logic       cfg_repair = 1'b1;

  texel_fix_t pending_fixes[$];
  dir_row_t   dir_rows[$];
  int         mismatches = 0;
  int         results_seen = 0;
  int         cycles = 0;
  int         hold_left = 0;
  logic       long_hold_done = 1'b0;
  logic       quiet = 1'b0;

  alpha_over_opacity_repair DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("alpha_over_opacity_repair test failed");
      $finish;
    end
  end

  function automatic logic [31:0] tex(input int w0, input int w1,
                                      input int w2, input int w3);
    return {8'(w3), 8'(w2), 8'(w1), 8'(w0)};
  endfunction

  function automatic texel_fix_t fix(input int f0, input int f1,
                                     input int f2, input int f3,
                                     input int exc, input int rep);
    texel_fix_t r;
    r.fixed    = {8'(f3), 8'(f2), 8'(f1), 8'(f0)};
    r.excess   = SUM_W'(exc);
    r.repaired = 1'(rep);
    return r;
  endfunction

  // Computes the repaired weights of one texel under the current register copy.
  function automatic texel_fix_t repair_texel(input logic [31:0] texel);
    texel_fix_t  r;
    int unsigned w[NLANES];
    int unsigned quo[NLANES];
    int unsigned rem[NLANES];
    int unsigned n, sum, over, cut, given, left, best, k;
    logic        stuck;
    n   = (cfg_layers > MAX_LAYERS) ? MAX_LAYERS : cfg_layers;
    sum = 0;
    r   = '0;
    for (k = 0; k < NLANES; k++) begin
      w[k]   = (k < n) ? texel[8*k +: 8] : 0;
      quo[k] = 0;
      rem[k] = 0;
      sum   += w[k];
    end
    if (sum > int'(OPAQUE)) begin
      over     = sum - int'(OPAQUE);
      r.excess = over[SUM_W-1:0];
      if (cfg_repair) begin
        r.repaired = 1'b1;
        if (cfg_scale) begin
          given = 0;
          for (k = 0; k < n; k++) begin
            quo[k] = w[k] * int'(OPAQUE) / sum;
            rem[k] = w[k] * int'(OPAQUE) % sum;
            given += quo[k];
          end
          // Leftover units go to the largest non-zero remainders, lower index on ties.
          left  = int'(OPAQUE) - given;
          stuck = 1'b0;
          while (left > 0 && !stuck) begin
            best = NLANES;
            for (k = 0; k < n; k++) begin
              if (rem[k] > 0 && (best == NLANES || rem[k] > rem[best])) best = k;
            end
            if (best == NLANES) begin
              stuck = 1'b1;
            end else begin
              quo[best]++;
              rem[best] = 0;
              left--;
            end
          end
          for (k = 0; k < n; k++) w[k] = quo[k];
        end else begin
          k = n;
          while (k > 0 && over > 0) begin
            k--;
            cut   = (w[k] < over) ? w[k] : over;
            w[k] -= cut;
            over -= cut;
          end
        end
      end
    end
    for (k = 0; k < NLANES; k++) r.fixed[k] = w[k][7:0];
    return r;
  endfunction

  function automatic logic [31:0] random_texel();
    logic [7:0]  w[NLANES];
    int unsigned target, rest, k;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: begin
        for (k = 0; k < NLANES; k++) w[k] = 8'($urandom_range(0, 63));
      end
      2: begin
        // Sums right around the opaque threshold.
        target = 254 + $urandom_range(0, 3);
        rest   = target;
        for (k = 0; k < NLANES - 1; k++) begin
          w[k]  = 8'($urandom_range(0, (rest > 255) ? 255 : rest));
          rest -= w[k];
        end
        w[NLANES-1] = (rest > 255) ? 8'd255 : 8'(rest);
      end
      3: begin
        for (k = 0; k < NLANES; k++) begin
          case ($urandom_range(0, 4))
            0: w[k] = 8'd0;
            1: w[k] = 8'd1;
            2: w[k] = 8'd128;
            3: w[k] = 8'd254;
            default: w[k] = 8'd255;
          endcase
        end
      end
      default: begin
        for (k = 0; k < NLANES; k++) w[k] = 8'($urandom_range(100, 255));
      end
    endcase
    return {w[3], w[2], w[1], w[0]};
  endfunction

  task automatic add_row(input logic [2:0] layers, input logic scale, input logic repair,
                         input logic [31:0] texel, input logic known, input texel_fix_t want);
    dir_row_t r;
    r.layers = layers;
    r.scale  = scale;
    r.repair = repair;
    r.texel  = texel;
    r.known  = known;
    r.want   = want;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LAYERS:        cfg_layers = value[2:0];
      REG_SCALE_MODE:    cfg_scale  = value[0];
      REG_REPAIR_ENABLE: cfg_repair = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Unused register bits are filled with noise; only the low bits count.
  task automatic set_config(input logic [2:0] layers, input logic scale, input logic repair);
    drain();
    write_reg(REG_LAYERS,        {29'($urandom), layers});
    write_reg(REG_SCALE_MODE,    {31'($urandom), scale});
    write_reg(REG_REPAIR_ENABLE, {31'($urandom), repair});
  endtask

  task automatic send_texel(input logic [31:0] texel, input logic known,
                            input texel_fix_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= texel;
    do @(posedge clk); while (!s_axis_tready);
    pending_fixes.insert(pending_fixes.size(), known ? want : repair_texel(texel));
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Result checker and output backpressure.
  always @(posedge clk) begin
    texel_fix_t exp_fix;
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_fixes.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        exp_fix = pending_fixes.pop_front();
        for (int k = 0; k < NLANES; k++) begin
          if (m_axis_tdata[8*k +: 8] !== exp_fix.fixed[k]) begin
            $display("%0t: fixed_%0d expected %0d actual %0d", $time, k,
                     exp_fix.fixed[k], m_axis_tdata[8*k +: 8]);
            mismatches++;
          end
        end
        if (m_axis_tdata[41:32] !== exp_fix.excess) begin
          $display("%0t: excess_amount expected %0d actual %0d", $time,
                   exp_fix.excess, m_axis_tdata[41:32]);
          mismatches++;
        end
        if (m_axis_tuser !== exp_fix.repaired) begin
          $display("%0t: was_repaired expected %0d actual %0d", $time,
                   exp_fix.repaired, m_axis_tuser);
          mismatches++;
        end
      end
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (!quiet && !long_hold_done && results_seen >= LONG_HOLD_AT) begin
      // One long hold-off so the pipeline fills and stalls its input.
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD_LEN - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      hold_left      = $urandom_range(1, 10) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    logic [2:0] layers;
    logic       scale, repair;

    // Reset configuration first, then clip, pass-through, scale, layer count edges.
    add_row(3'd4, 1'b0, 1'b1, tex(0, 0, 0, 0),         1'b1, fix(0, 0, 0, 0, 0, 0));
    add_row(3'd4, 1'b0, 1'b1, tex(255, 0, 0, 0),       1'b1, fix(255, 0, 0, 0, 0, 0));
    add_row(3'd4, 1'b0, 1'b1, tex(255, 255, 255, 255), 1'b1, fix(255, 0, 0, 0, 765, 1));
    add_row(3'd4, 1'b0, 1'b1, tex(100, 100, 100, 0),   1'b1, fix(100, 100, 55, 0, 45, 1));
    add_row(3'd4, 1'b0, 1'b1, tex(128, 128, 0, 0),     1'b1, fix(128, 127, 0, 0, 1, 1));
    add_row(3'd4, 1'b0, 1'b1, tex(8'h55, 8'hAA, 8'h55, 8'hAA), 1'b0, '0);
    add_row(3'd4, 1'b0, 1'b0, tex(200, 200, 0, 0),     1'b1, fix(200, 200, 0, 0, 145, 0));
    add_row(3'd4, 1'b0, 1'b0, tex(255, 255, 255, 255), 1'b1, fix(255, 255, 255, 255, 765, 0));
    add_row(3'd4, 1'b1, 1'b1, tex(255, 255, 255, 255), 1'b1, fix(64, 64, 64, 63, 765, 1));
    add_row(3'd4, 1'b1, 1'b1, tex(128, 128, 0, 0),     1'b1, fix(128, 127, 0, 0, 1, 1));
    add_row(3'd4, 1'b1, 1'b1, tex(255, 255, 0, 0),     1'b1, fix(128, 127, 0, 0, 255, 1));
    add_row(3'd4, 1'b1, 1'b1, tex(1, 2, 3, 250),       1'b0, '0);
    add_row(3'd4, 1'b1, 1'b1, tex(0, 0, 200, 56),      1'b0, '0);
    add_row(3'd4, 1'b1, 1'b1, tex(8'hAA, 8'h55, 8'hAA, 8'h55), 1'b0, '0);
    add_row(3'd3, 1'b1, 1'b1, tex(170, 170, 170, 255), 1'b1, fix(85, 85, 85, 0, 255, 1));
    add_row(3'd2, 1'b1, 1'b1, tex(255, 1, 9, 9),       1'b1, fix(254, 1, 0, 0, 1, 1));
    add_row(3'd1, 1'b0, 1'b1, tex(255, 255, 255, 255), 1'b1, fix(255, 0, 0, 0, 0, 0));
    add_row(3'd1, 1'b1, 1'b1, tex(7, 255, 255, 255),   1'b1, fix(7, 0, 0, 0, 0, 0));
    add_row(3'd0, 1'b0, 1'b1, tex(255, 255, 255, 255), 1'b1, fix(0, 0, 0, 0, 0, 0));
    add_row(3'd0, 1'b1, 1'b1, tex(1, 2, 3, 4),         1'b1, fix(0, 0, 0, 0, 0, 0));
    add_row(3'd7, 1'b0, 1'b1, tex(255, 255, 255, 255), 1'b1, fix(255, 0, 0, 0, 765, 1));
    add_row(3'd5, 1'b1, 1'b1, tex(255, 255, 255, 255), 1'b1, fix(64, 64, 64, 63, 765, 1));
    add_row(3'd6, 1'b1, 1'b0, tex(200, 100, 0, 0),     1'b1, fix(200, 100, 0, 0, 45, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].layers != cfg_layers || dir_rows[i].scale != cfg_scale ||
          dir_rows[i].repair != cfg_repair) begin
        set_config(dir_rows[i].layers, dir_rows[i].scale, dir_rows[i].repair);
      end
      maybe_gap();
      send_texel(dir_rows[i].texel, dir_rows[i].known, dir_rows[i].want);
    end

    // A write past the last register must leave the configuration alone.
    drain();
    write_reg(REG_UNUSED, '1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin layers = 3'd4; scale = 1'b1; repair = 1'b1; end
        1: begin layers = 3'd4; scale = 1'b0; repair = 1'b1; end
        2: begin layers = 3'd1; scale = 1'b1; repair = 1'b1; end
        3: begin layers = 3'd2; scale = 1'b0; repair = 1'b1; end
        4: begin layers = 3'd3; scale = 1'b1; repair = 1'b1; end
        5: begin layers = 3'd0; scale = 1'b1; repair = 1'b1; end
        6: begin layers = 3'd7; scale = 1'b1; repair = 1'b1; end
        7: begin layers = 3'd4; scale = 1'b1; repair = 1'b0; end
        default: begin
          layers = 3'($urandom_range(0, 7));
          scale  = 1'($urandom);
          repair = ($urandom_range(0, 3) != 0);
        end
      endcase
      if (p > 0) set_config(layers, scale, repair);
      else begin
        set_config(layers, scale, repair);
      end
      if (p == PHASES - 1) quiet = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        maybe_gap();
        send_texel(random_texel(), 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (mismatches == 0 && pending_fixes.size() == 0) begin
      $display("alpha_over_opacity_repair test passed");
    end else begin
      $display("alpha_over_opacity_repair test failed");
    end
    $finish;
  end

endmodule
